/* rtl/pssg_pkg.sv */
`default_nettype none

package pssg_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // channel codes
    localparam logic [1:0] CH_PULSE_A = 2'd0;
    localparam logic [1:0] CH_PULSE_B = 2'd1;
    localparam logic [1:0] CH_SAW     = 2'd2;

    // channel register codes
    localparam logic [1:0] CREG_CTRL      = 2'd0;
    localparam logic [1:0] CREG_PERIOD_LO = 2'd1;
    localparam logic [1:0] CREG_PERIOD_HI = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_STEP  = 2'd0;
    localparam logic [1:0] CFG_EMULATION_ON = 2'd1;
    localparam logic [1:0] CFG_OUTPUT_GAIN  = 2'd2;

    localparam logic [23:0] SAMPLE_STEP_RST = 24'd2660000;
    localparam logic [9:0]  OUTPUT_GAIN_RST = 10'd256;

    typedef struct packed {
        logic       func;
        logic [1:0] channel;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } in_t;

    typedef struct packed {
        logic signed [15:0] pulse_a_out;
        logic signed [15:0] pulse_b_out;
        logic [15:0]        saw_out;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_LOAD,
        ST_ITER,
        ST_DECAY,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* rtl/pulse_sawtooth_sound_generator.sv */
// Three-channel tone generator: two pulse channels and one sawtooth channel.
// Input channel (s_valid/s_ready/s_data): each transfer is either a channel
// register write or a sample tick. A write is taken while idle and gives
// no result. A tick walks the three channels in turn through one shared
// timer adder and gives one result transfer (m_valid/m_ready/m_data) with
// the three channel levels.
// Per tick: a disabled channel passes through select and decay; an enabled
// one through select, load, one iterate step per advance and a final
// iterate step, where the number of advances is ceil((timer + sample_step)
// / timer period). With the reset configuration and period 0 a pulse
// channel advances about 41 times per tick. The result becomes valid in the
// same cycle in which s_ready rises again. The single timer adder, one add
// or subtract a cycle, sets the rate; s_ready is high only while no tick is
// in progress.
// A finished result sits in the output register; while the receiver stalls
// the block still takes writes and can work on the next tick, and only
// waits at the end of that tick until the output register is free.
// Reset (aresetn, synchronous, active low) clears all channel state and
// loads sample_step 2660000, emulation_on 1 and output_gain 256.
`default_nettype none

module pulse_sawtooth_sound_generator
    import pssg_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input items
    input  wire         s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    // results
    output logic        m_valid,
    input  wire         m_ready,
    output out_t        m_data,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // timer arithmetic width: covers sample_step, the longest saw period and -2^31
    localparam int TW = (FRACTION_BITS + 15 > 33) ? FRACTION_BITS + 15 : 33;
    localparam logic signed [TW-1:0] TIMER_MIN = {{(TW-31){1'b1}}, 31'd0};

    // configuration registers
    logic [23:0] sample_step_reg;
    logic        emulation_on_reg;
    logic [9:0]  output_gain_reg;

    // sequencer
    state_t state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic signed [TW-1:0] t_reg, t_next;

    // pulse channel state
    logic signed [31:0] pulse_timer_reg [2];
    logic signed [31:0] pulse_timer_next [2];
    logic [3:0]  pulse_step_reg [2];
    logic [3:0]  pulse_step_next [2];
    logic [3:0]  pulse_duty_reg [2];
    logic [3:0]  pulse_duty_next [2];
    logic [13:0] pulse_volume_reg [2];
    logic [13:0] pulse_volume_next [2];
    logic [11:0] pulse_period_reg [2];
    logic [11:0] pulse_period_next [2];
    logic        pulse_enable_reg [2];
    logic        pulse_enable_next [2];
    logic signed [16:0] pulse_level_reg [2];
    logic signed [16:0] pulse_level_next [2];

    // sawtooth channel state
    logic signed [31:0] saw_timer_reg, saw_timer_next;
    logic [2:0]  saw_step_reg, saw_step_next;
    logic [12:0] saw_rate_reg, saw_rate_next;
    logic [11:0] saw_period_reg, saw_period_next;
    logic        saw_enable_reg, saw_enable_next;
    logic signed [16:0] saw_level_reg, saw_level_next;

    // output register
    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;

    // datapath signals
    logic               pidx;
    logic               is_saw;
    logic               ch_active;
    logic [11:0]        period_sel;
    logic [12:0]        period_p1;
    logic [TW-1:0]      freq_base;
    logic [TW-1:0]      freq;
    logic signed [31:0] timer_sel;
    logic signed [16:0] level_sel;
    logic signed [16:0] level_decayed;
    logic signed [TW-1:0] add_a;
    logic signed [TW-1:0] add_b;
    logic               add_cin;
    logic signed [TW-1:0] add_sum;
    logic               t_pos;
    logic signed [31:0] t_clamped;
    logic [13:0]        vol_prod;
    logic [15:0]        rate_prod;
    logic [3:0]         pstep_inc;
    logic [2:0]         sstep_inc;
    logic signed [16:0] vol_level;
    logic               wr_take;
    logic               out_free;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            CFG_SAMPLE_STEP:  prdata = {8'd0, sample_step_reg};
            CFG_EMULATION_ON: prdata = {31'd0, emulation_on_reg};
            CFG_OUTPUT_GAIN:  prdata = {22'd0, output_gain_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_step_reg  <= SAMPLE_STEP_RST;
            emulation_on_reg <= 1'b1;
            output_gain_reg  <= OUTPUT_GAIN_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_SAMPLE_STEP:  sample_step_reg  <= pwdata[23:0];
                CFG_EMULATION_ON: emulation_on_reg <= pwdata[0];
                CFG_OUTPUT_GAIN:  output_gain_reg  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // shared datapath
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign wr_take  = s_valid && s_ready && (s_data.func == FUNC_WRITE);
    assign out_free = !m_valid_reg || m_ready;

    assign pidx   = ch_reg[0];
    assign is_saw = (ch_reg == CH_SAW);

    assign period_sel = is_saw ? saw_period_reg : pulse_period_reg[pidx];
    assign period_p1  = {1'b0, period_sel} + 13'd1;
    assign freq_base  = TW'(period_p1) << FRACTION_BITS;
    assign freq       = is_saw ? (freq_base << 1) : freq_base;

    assign timer_sel = is_saw ? saw_timer_reg : pulse_timer_reg[pidx];
    assign level_sel = is_saw ? saw_level_reg : pulse_level_reg[pidx];
    assign ch_active = emulation_on_reg && (is_saw ? saw_enable_reg : pulse_enable_reg[pidx]);

    // level >>> 7 is the floor shift for both signs
    assign level_decayed = level_sel - (level_sel >>> 7);

    // one adder: timer + step on load, t - period on each advance
    assign add_a   = (state_reg == ST_LOAD) ? TW'(timer_sel) : t_reg;
    assign add_b   = (state_reg == ST_LOAD) ? TW'(sample_step_reg) : ~freq;
    assign add_cin = (state_reg != ST_LOAD);
    assign add_sum = add_a + add_b + TW'(add_cin);

    assign t_pos     = !t_reg[TW-1] && (t_reg != '0);
    assign t_clamped = (t_reg < TIMER_MIN) ? 32'sh8000_0000 : t_reg[31:0];

    assign vol_prod  = {10'd0, s_data.write_data[3:0]} * {4'd0, output_gain_reg};
    assign rate_prod = {10'd0, s_data.write_data[5:0]} * {6'd0, output_gain_reg};

    assign pstep_inc = pulse_step_reg[pidx] + 4'd1;
    assign sstep_inc = saw_step_reg + 3'd1;
    assign vol_level = $signed({3'd0, pulse_volume_reg[pidx]});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_data.func == FUNC_TICK) state_next = ST_SEL;
            end
            ST_SEL: begin
                state_next = ch_active ? ST_LOAD : ST_DECAY;
            end
            ST_LOAD: begin
                state_next = ST_ITER;
            end
            ST_ITER: begin
                if (!t_pos) state_next = is_saw ? ST_OUT : ST_SEL;
            end
            ST_DECAY: begin
                state_next = is_saw ? ST_OUT : ST_SEL;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // register updates
    always_comb begin
        ch_next = ch_reg;
        t_next  = t_reg;
        for (int i = 0; i < 2; i++) begin
            pulse_timer_next[i]  = pulse_timer_reg[i];
            pulse_step_next[i]   = pulse_step_reg[i];
            pulse_duty_next[i]   = pulse_duty_reg[i];
            pulse_volume_next[i] = pulse_volume_reg[i];
            pulse_period_next[i] = pulse_period_reg[i];
            pulse_enable_next[i] = pulse_enable_reg[i];
            pulse_level_next[i]  = pulse_level_reg[i];
        end
        saw_timer_next  = saw_timer_reg;
        saw_step_next   = saw_step_reg;
        saw_rate_next   = saw_rate_reg;
        saw_period_next = saw_period_reg;
        saw_enable_next = saw_enable_reg;
        saw_level_next  = saw_level_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                ch_next = CH_PULSE_A;
                if (wr_take) begin
                    case (s_data.channel)
                        CH_PULSE_A, CH_PULSE_B: begin
                            case (s_data.reg_index)
                                CREG_CTRL: begin
                                    pulse_duty_next[s_data.channel[0]] =
                                        {1'b0, s_data.write_data[6:4]} + 4'd1;
                                    pulse_volume_next[s_data.channel[0]] = vol_prod;
                                end
                                CREG_PERIOD_LO: begin
                                    pulse_period_next[s_data.channel[0]][7:0] =
                                        s_data.write_data;
                                end
                                CREG_PERIOD_HI: begin
                                    pulse_period_next[s_data.channel[0]][11:8] =
                                        s_data.write_data[3:0];
                                    pulse_enable_next[s_data.channel[0]] =
                                        s_data.write_data[7];
                                end
                                default: ;
                            endcase
                        end
                        CH_SAW: begin
                            case (s_data.reg_index)
                                CREG_CTRL:      saw_rate_next = rate_prod[15:3];
                                CREG_PERIOD_LO: saw_period_next[7:0] = s_data.write_data;
                                CREG_PERIOD_HI: begin
                                    saw_period_next[11:8] = s_data.write_data[3:0];
                                    saw_enable_next       = s_data.write_data[7];
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                t_next = add_sum;
            end
            ST_ITER: begin
                if (t_pos) begin
                    t_next = add_sum;
                    if (is_saw) begin
                        if (sstep_inc == 3'd7) begin
                            saw_step_next  = 3'd0;
                            saw_level_next = '0;
                        end else begin
                            saw_step_next  = sstep_inc;
                            saw_level_next = saw_level_reg + $signed({4'd0, saw_rate_reg});
                        end
                    end else begin
                        pulse_step_next[pidx] = pstep_inc;
                        if (pstep_inc == 4'd0) begin
                            pulse_level_next[pidx] = vol_level;
                        end else if (pstep_inc == pulse_duty_reg[pidx]) begin
                            pulse_level_next[pidx] = -vol_level;
                        end
                    end
                end else begin
                    // timer has run out: store it and move on
                    if (is_saw) begin
                        saw_timer_next = t_clamped;
                    end else begin
                        pulse_timer_next[pidx] = t_clamped;
                        ch_next = ch_reg + 2'd1;
                    end
                end
            end
            ST_DECAY: begin
                if (is_saw) begin
                    saw_level_next = level_decayed;
                end else begin
                    pulse_level_next[pidx] = level_decayed;
                    ch_next = ch_reg + 2'd1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.pulse_a_out = pulse_level_reg[0][15:0];
                    m_data_next.pulse_b_out = pulse_level_reg[1][15:0];
                    m_data_next.saw_out     = saw_level_reg[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= CH_PULSE_A;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                pulse_timer_reg[i]  <= '0;
                pulse_step_reg[i]   <= '0;
                pulse_duty_reg[i]   <= '0;
                pulse_volume_reg[i] <= '0;
                pulse_period_reg[i] <= '0;
                pulse_enable_reg[i] <= 1'b0;
                pulse_level_reg[i]  <= '0;
            end
            saw_timer_reg  <= '0;
            saw_step_reg   <= '0;
            saw_rate_reg   <= '0;
            saw_period_reg <= '0;
            saw_enable_reg <= 1'b0;
            saw_level_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 2; i++) begin
                pulse_timer_reg[i]  <= pulse_timer_next[i];
                pulse_step_reg[i]   <= pulse_step_next[i];
                pulse_duty_reg[i]   <= pulse_duty_next[i];
                pulse_volume_reg[i] <= pulse_volume_next[i];
                pulse_period_reg[i] <= pulse_period_next[i];
                pulse_enable_reg[i] <= pulse_enable_next[i];
                pulse_level_reg[i]  <= pulse_level_next[i];
            end
            saw_timer_reg  <= saw_timer_next;
            saw_step_reg   <= saw_step_next;
            saw_rate_reg   <= saw_rate_next;
            saw_period_reg <= saw_period_next;
            saw_enable_reg <= saw_enable_next;
            saw_level_reg  <= saw_level_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

/* rtl/pssg_checker.sv */
`default_nettype none

module pssg_checker
    import pssg_pkg::*;
(
    input wire         aclk,
    input wire         aresetn,
    input wire         s_valid,
    input wire         s_ready,
    input in_t         s_data,
    input wire         m_valid,
    input wire         m_ready,
    input out_t        m_data,
    input wire         psel,
    input wire         pwrite,
    input wire  [3:0]  paddr,
    input wire  [31:0] prdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // a tick transfer starts the channel walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_TICK |=> !s_ready)
        else $error("input still ready after a tick transfer");

    // a register write never produces a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_WRITE && !m_valid |=> !m_valid)
        else $error("result appeared after a register write");

    // a result only appears at the end of a tick, while input is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared with no tick in progress");

    // emulation_on reads back as a single bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !pwrite && paddr[3:2] == CFG_EMULATION_ON |-> prdata[31:1] == 31'd0)
        else $error("emulation_on readback has stray bits");

endmodule

bind pulse_sawtooth_sound_generator pssg_checker u_pssg_checker (.*);

`default_nettype wire
